FILE: rtl/fmu_pkg.sv
// Shared types, constants and tables of the fuzzy membership update block.
`timescale 1ns / 1ps
package fmu_pkg;

	localparam int MAX_CLUSTERS_DEF = 16;

	// configuration register indexes
	localparam logic [1:0] CFG_COUNT = 2'd0;
	localparam logic [1:0] CFG_EXPO  = 2'd1;
	localparam logic [1:0] CFG_TOL   = 2'd2;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	typedef struct packed {
		logic [3:0]  cluster;
		logic [23:0] weight;
		logic [31:0] dissimilarity;
		logic        last_term;
	} in_t;

	typedef struct packed {
		logic [3:0]  cluster_index;
		logic [15:0] membership;
		logic        degenerate;
		logic        last;
	} out_t;

	typedef struct packed {
		logic       load_term;
		logic       acc;
		logic       rd_sum;
		logic       zchk;
		logic       fin_init;
		logic       emit_degen;
		logic       norm_load;
		logic       norm_shift;
		logic       sq_init;
		logic       sq_step;
		logic       amul;
		logic       rd_a;
		logic       exp_init;
		logic       exp_step;
		logic       exp_fin;
		logic       rd_pw;
		logic       div_init;
		logic       div_step;
		logic       emit_memb;
		logic       clear;
		logic       last_k;
		logic [3:0] k;
		logic [3:0] iter;
	} cmd_t;

	typedef struct packed {
		logic       last_term;
		logic       norm_top;
		logic       degen;
		logic       out_free;
		logic [4:0] cnt_eff;
	} stat_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (b > v)
				b = b >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(-2^-i) in Q1.30, built as a chain of floor square roots
	function automatic logic [30:0] pow_entry(int i);
		logic [63:0] p;
		p = 64'd1 << 29;
		for (int j = 1; j <= 16; j++) begin
			if (j <= i)
				p = isqrt64(p << 30);
		end
		return p[30:0];
	endfunction

	localparam logic [30:0] POW_TAB [17] = '{
		pow_entry(0),  pow_entry(1),  pow_entry(2),  pow_entry(3),
		pow_entry(4),  pow_entry(5),  pow_entry(6),  pow_entry(7),
		pow_entry(8),  pow_entry(9),  pow_entry(10), pow_entry(11),
		pow_entry(12), pow_entry(13), pow_entry(14), pow_entry(15),
		pow_entry(16)
	};

	// rounded 1/a in Q1.15 for a tied clusters
	function automatic logic [15:0] recip_q15(logic [4:0] a);
		logic [15:0] v;
		case (a)
			5'd1:    v = 16'd32768;
			5'd2:    v = 16'd16384;
			5'd3:    v = 16'd10923;
			5'd4:    v = 16'd8192;
			5'd5:    v = 16'd6554;
			5'd6:    v = 16'd5461;
			5'd7:    v = 16'd4681;
			5'd8:    v = 16'd4096;
			5'd9:    v = 16'd3641;
			5'd10:   v = 16'd3277;
			5'd11:   v = 16'd2979;
			5'd12:   v = 16'd2731;
			5'd13:   v = 16'd2521;
			5'd14:   v = 16'd2341;
			5'd15:   v = 16'd2185;
			5'd16:   v = 16'd2048;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/fmu_datapath.sv
// Datapath: cluster sums, log2 and exp2 units, divider, output register.
`timescale 1ns / 1ps
module fmu_datapath #(
	parameter int MAX_CLUSTERS = fmu_pkg::MAX_CLUSTERS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fmu_pkg::cmd_t  cmd,
	output fmu_pkg::stat_t st,
	input  fmu_pkg::in_t   in_data,
	input  logic           cfg_valid,
	input  logic [1:0]     cfg_index,
	input  logic [23:0]    cfg_data,
	output logic           out_valid,
	input  logic           out_ready,
	output fmu_pkg::out_t  out_data
);

	localparam int AW = $clog2(MAX_CLUSTERS);
	localparam int TW = 31 + AW;
	localparam int DW = TW + 15;
	localparam int HI_COUNT = (MAX_CLUSTERS < 16) ? MAX_CLUSTERS : 16;

	logic [4:0]  count_q;
	logic [23:0] expo_q;
	logic [15:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd2;
			expo_q  <= 24'd65536;
			tol_q   <= 16'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fmu_pkg::CFG_COUNT: count_q <= cfg_data[4:0];
				fmu_pkg::CFG_EXPO:  expo_q  <= cfg_data;
				fmu_pkg::CFG_TOL:   tol_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [4:0] cnt_eff;
	always_comb begin
		cnt_eff = count_q;
		if (cnt_eff < 5'd2)
			cnt_eff = 5'd2;
		if (cnt_eff > 5'(HI_COUNT))
			cnt_eff = 5'(HI_COUNT);
	end

	// latched term
	logic [3:0]  term_cl_q;
	logic [23:0] term_w_q;
	logic [31:0] term_d_q;
	logic        term_last_q;

	always_ff @(posedge clk) begin
		if (cmd.load_term) begin
			term_cl_q <= in_data.cluster;
			term_w_q  <= in_data.weight;
			term_d_q  <= in_data.dissimilarity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			term_last_q <= 1'b0;
		else if (cmd.load_term)
			term_last_q <= in_data.last_term;
	end

	// sum memory with per-entry valid bits
	logic [63:0]           sum_mem [MAX_CLUSTERS];
	logic [63:0]           sum_rd_q;
	logic                  vld_rd_q;
	logic [MAX_CLUSTERS-1:0] vld_q;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         kaddr;
	logic                  rd_en;
	logic                  acc_we;
	logic [63:0]           sum_eff;
	logic [55:0]           prod;
	logic [64:0]           sum_add;
	logic [63:0]           acc_sum;

	assign kaddr   = AW'(cmd.k);
	assign rd_en   = cmd.load_term | cmd.rd_sum;
	assign rd_addr = cmd.load_term ? AW'(in_data.cluster) : kaddr;
	assign wr_addr = AW'(term_cl_q);
	assign acc_we  = cmd.acc && (int'(term_cl_q) < MAX_CLUSTERS);
	assign sum_eff = vld_rd_q ? sum_rd_q : 64'd0;
	assign prod    = 56'(term_w_q) * 56'(term_d_q);
	assign sum_add = {1'b0, sum_eff} + 65'(prod);
	assign acc_sum = sum_add[64] ? '1 : sum_add[63:0];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sum_rd_q <= sum_mem[rd_addr];
			vld_rd_q <= vld_q[rd_addr];
		end
		if (acc_we)
			sum_mem[wr_addr] <= acc_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (cmd.clear)
			vld_q <= '0;
		else if (acc_we)
			vld_q[wr_addr] <= 1'b1;
	end

	// count of sums within tolerance
	logic [4:0] zeros_q;
	logic       in_tol;
	assign in_tol = sum_eff <= 64'(tol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			zeros_q <= '0;
		else if (cmd.acc)
			zeros_q <= '0;
		else if (cmd.zchk && in_tol)
			zeros_q <= zeros_q + 5'd1;
	end

	// log2: normalize one bit per cycle, then 16 squarings
	logic [63:0] norm_q;
	logic [5:0]  nbit_q;
	logic [30:0] m_q;
	logic [21:0] res_q;
	logic [61:0] sq;
	logic [31:0] sq_sh;

	assign sq    = 62'(m_q) * 62'(m_q);
	assign sq_sh = sq[61:30];

	always_ff @(posedge clk) begin
		if (cmd.norm_load) begin
			norm_q <= sum_eff;
			nbit_q <= 6'd63;
		end else if (cmd.norm_shift) begin
			norm_q <= norm_q << 1;
			nbit_q <= nbit_q - 6'd1;
		end
		if (cmd.sq_init) begin
			m_q   <= norm_q[63:33];
			res_q <= {nbit_q, 16'd0};
		end else if (cmd.sq_step) begin
			res_q[cmd.iter] <= sq_sh[31];
			m_q <= sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
		end
	end

	// scaled logs and their minimum
	logic [45:0] a_mem [MAX_CLUSTERS];
	logic [45:0] a_rd_q;
	logic [45:0] amin_q;
	logic [45:0] a_val;
	assign a_val = 46'(expo_q) * 46'(res_q);

	always_ff @(posedge clk) begin
		if (cmd.amul)
			a_mem[kaddr] <= a_val;
		if (cmd.rd_a)
			a_rd_q <= a_mem[kaddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_init)
			amin_q <= '1;
		else if (cmd.amul && a_val < amin_q)
			amin_q <= a_val;
	end

	// exp2 of the negated distance, one fraction bit per cycle
	logic [45:0] adiff;
	logic [13:0] en_q;
	logic [15:0] f_q;
	logic [30:0] r_q;
	logic [4:0]  pidx;
	logic [61:0] rp;
	logic [30:0] pw;
	logic [30:0] pw_mem [MAX_CLUSTERS];
	logic [30:0] pw_rd_q;
	logic [TW-1:0] total_q;

	assign adiff = a_rd_q - amin_q;
	assign pidx  = 5'd16 - 5'(cmd.iter);
	assign rp    = 62'(r_q) * 62'(fmu_pkg::POW_TAB[pidx]);
	assign pw    = (en_q >= 14'd31) ? 31'd0 : (r_q >> en_q[4:0]);

	always_ff @(posedge clk) begin
		if (cmd.exp_init) begin
			en_q <= adiff[45:32];
			f_q  <= adiff[31:16];
			r_q  <= fmu_pkg::ONE_Q30;
		end else if (cmd.exp_step && f_q[cmd.iter]) begin
			r_q <= rp[60:30];
		end
		if (cmd.exp_fin)
			pw_mem[kaddr] <= pw;
		if (cmd.rd_pw)
			pw_rd_q <= pw_mem[kaddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_init)
			total_q <= '0;
		else if (cmd.exp_fin)
			total_q <= total_q + TW'(pw);
	end

	// restoring divider, 16 quotient bits
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsh_q;
	logic [15:0]   q_q;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= (DW'(pw_rd_q) << 15) + DW'(total_q >> 1);
			dsh_q <= DW'(total_q) << 15;
			q_q   <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[14:0], 1'b1};
			end else begin
				q_q   <= {q_q[14:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	// output register
	logic          out_valid_q;
	fmu_pkg::out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_degen || cmd.emit_memb)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_degen) begin
			out_q.cluster_index <= cmd.k;
			out_q.membership    <= in_tol ? fmu_pkg::recip_q15(zeros_q) : 16'd0;
			out_q.degenerate    <= 1'b1;
			out_q.last          <= cmd.last_k;
		end else if (cmd.emit_memb) begin
			out_q.cluster_index <= cmd.k;
			out_q.membership    <= q_q;
			out_q.degenerate    <= 1'b0;
			out_q.last          <= cmd.last_k;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign st.last_term = term_last_q;
	assign st.norm_top  = norm_q[63];
	assign st.degen     = zeros_q != 5'd0;
	assign st.out_free  = !out_valid_q || out_ready;
	assign st.cnt_eff   = cnt_eff;

`ifndef SYNTHESIS
	// normalized mantissa stays in [1,2)
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sq_step |-> m_q[30])
		else $error("mantissa lost its leading one");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exp_step |-> r_q <= fmu_pkg::ONE_Q30)
		else $error("power above one");

	// the minimum cluster contributes one, so the divisor is never small
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |-> total_q >= TW'(fmu_pkg::ONE_Q30))
		else $error("membership divisor below one");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_memb |-> q_q <= 16'd32768)
		else $error("membership above one");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_memb || cmd.emit_degen) |-> st.out_free)
		else $error("item emitted over a pending one");
`endif

endmodule

FILE: rtl/fmu_ctrl.sv
// Controller: sequences accumulation and the per-cluster finish passes.
`timescale 1ns / 1ps
module fmu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fmu_pkg::stat_t st,
	output fmu_pkg::cmd_t  cmd
);

	typedef enum logic [20:0] {
		S_IDLE   = 21'h000001,
		S_ACC    = 21'h000002,
		S_ZRD    = 21'h000004,
		S_ZCHK   = 21'h000008,
		S_BRANCH = 21'h000010,
		S_DRD    = 21'h000020,
		S_DOUT   = 21'h000040,
		S_LRD    = 21'h000080,
		S_NORM   = 21'h000100,
		S_NSHIFT = 21'h000200,
		S_SQ     = 21'h000400,
		S_AMUL   = 21'h000800,
		S_ERD    = 21'h001000,
		S_ESET   = 21'h002000,
		S_EMUL   = 21'h004000,
		S_EFIN   = 21'h008000,
		S_ORD    = 21'h010000,
		S_DSET   = 21'h020000,
		S_DIV    = 21'h040000,
		S_OUT    = 21'h080000,
		S_CLR    = 21'h100000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] k_q, k_d;
	logic [3:0] iter_q, iter_d;
	logic       last_k;

	assign last_k   = 5'(k_q) == st.cnt_eff - 5'd1;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		iter_d  = iter_q;
		cmd     = '0;
		cmd.k      = k_q;
		cmd.iter   = iter_q;
		cmd.last_k = last_k;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_term = 1'b1;
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				k_d = '0;
				state_d = st.last_term ? S_ZRD : S_IDLE;
			end
			S_ZRD: begin
				cmd.rd_sum = 1'b1;
				state_d = S_ZCHK;
			end
			S_ZCHK: begin
				cmd.zchk = 1'b1;
				if (last_k) begin
					state_d = S_BRANCH;
				end else begin
					k_d = k_q + 4'd1;
					state_d = S_ZRD;
				end
			end
			S_BRANCH: begin
				cmd.fin_init = 1'b1;
				k_d = '0;
				state_d = st.degen ? S_DRD : S_LRD;
			end
			S_DRD: begin
				cmd.rd_sum = 1'b1;
				state_d = S_DOUT;
			end
			S_DOUT: begin
				if (st.out_free) begin
					cmd.emit_degen = 1'b1;
					k_d = k_q + 4'd1;
					state_d = last_k ? S_CLR : S_DRD;
				end
			end
			S_LRD: begin
				cmd.rd_sum = 1'b1;
				state_d = S_NORM;
			end
			S_NORM: begin
				cmd.norm_load = 1'b1;
				state_d = S_NSHIFT;
			end
			S_NSHIFT: begin
				if (st.norm_top) begin
					cmd.sq_init = 1'b1;
					iter_d = 4'd15;
					state_d = S_SQ;
				end else begin
					cmd.norm_shift = 1'b1;
				end
			end
			S_SQ: begin
				cmd.sq_step = 1'b1;
				iter_d = iter_q - 4'd1;
				if (iter_q == 4'd0)
					state_d = S_AMUL;
			end
			S_AMUL: begin
				cmd.amul = 1'b1;
				if (last_k) begin
					k_d = '0;
					state_d = S_ERD;
				end else begin
					k_d = k_q + 4'd1;
					state_d = S_LRD;
				end
			end
			S_ERD: begin
				cmd.rd_a = 1'b1;
				state_d = S_ESET;
			end
			S_ESET: begin
				cmd.exp_init = 1'b1;
				iter_d = 4'd15;
				state_d = S_EMUL;
			end
			S_EMUL: begin
				cmd.exp_step = 1'b1;
				iter_d = iter_q - 4'd1;
				if (iter_q == 4'd0)
					state_d = S_EFIN;
			end
			S_EFIN: begin
				cmd.exp_fin = 1'b1;
				if (last_k) begin
					k_d = '0;
					state_d = S_ORD;
				end else begin
					k_d = k_q + 4'd1;
					state_d = S_ERD;
				end
			end
			S_ORD: begin
				cmd.rd_pw = 1'b1;
				state_d = S_DSET;
			end
			S_DSET: begin
				cmd.div_init = 1'b1;
				iter_d = 4'd15;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				iter_d = iter_q - 4'd1;
				if (iter_q == 4'd0)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.emit_memb = 1'b1;
					k_d = k_q + 4'd1;
					state_d = last_k ? S_CLR : S_ORD;
				end
			end
			S_CLR: begin
				cmd.clear = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			iter_q  <= iter_d;
		end
	end

endmodule

FILE: rtl/fuzzy_membership_update.sv
// Top level of the fuzzy membership update block.
//
//  channel | signals                          | direction | moves
//  in      | in_valid, in_ready, in_data      | input     | one term item
//  out     | out_valid, out_ready, out_data   | output    | one membership item
//  cfg     | cfg_valid, cfg_ready, cfg_index, | input     | one register write
//          | cfg_data                         |           |
//
// A term passes through the sum memory read, then the saturating multiply-add.
// On a last term the finish walks the clusters: a zero scan checks each sum, a branch
// state follows, then either a read and a tied output per cluster, or a log2 pass
// (one-bit normalize shifter, 16 squarings), an exp2 pass (16 multiply steps) and a pass
// through the 16-step divider per cluster, plus a clear state.
// No term is taken during the finish; a stalled output holds the sequencer.
// Reset clears the control state and the sum valid bits and sets the configuration to its defaults.
`timescale 1ns / 1ps
module fuzzy_membership_update #(
	parameter int MAX_CLUSTERS = fmu_pkg::MAX_CLUSTERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fmu_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output fmu_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_data
);

	fmu_pkg::cmd_t  cmd;
	fmu_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	fmu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	fmu_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
